@@ rtl/fix_integrity_consensus_fsm_defines.svh @@
// Assertion macros for the fix integrity consensus monitor.
// Used by the top level only; no other dependencies.
`ifndef FIX_INTEGRITY_CONSENSUS_FSM_DEFINES_SVH
`define FIX_INTEGRITY_CONSENSUS_FSM_DEFINES_SVH
`ifndef SYNTHESIS
`define FIC_ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define FIC_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("reset check failed");
`else
`define FIC_ASSERT_CLK(name, prop)
`define FIC_ASSERT_RST(name, prop)
`endif
`endif

@@ rtl/fic_pkg.sv @@
// Shared types, constants and helper functions of the fix integrity monitor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package fic_pkg;
  localparam int COUNT_BITS = 8;
  localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [2:0] SEQ_LAST_STEP = 3'd7;

  localparam logic [2:0] REG_MAX_PTRACE = 3'd0;
  localparam logic [2:0] REG_MAX_ITRACE = 3'd1;
  localparam logic [2:0] REG_MAX_AGE    = 3'd2;
  localparam logic [2:0] REG_AP_MULT    = 3'd3;
  localparam logic [2:0] REG_AP_MIN     = 3'd4;
  localparam logic [2:0] REG_AP_MAX     = 3'd5;
  localparam logic [2:0] REG_MODE       = 3'd6;
  localparam logic [2:0] REG_STREAKS    = 3'd7;

  localparam logic [1:0] MS_NORMAL     = 2'd0;
  localparam logic [1:0] MS_SUSPECT    = 2'd1;
  localparam logic [1:0] MS_QUARANTINE = 2'd2;
  localparam logic [1:0] MS_RECOVERY   = 2'd3;

  localparam int R_UNAVAIL   = 0;
  localparam int R_UNCERTAIN = 1;
  localparam int R_DISAGREE  = 2;
  localparam int R_SUSPECT   = 3;
  localparam int R_GEN       = 4;

  typedef enum logic [3:0] {
    MON_NORMAL     = 4'b0001,
    MON_SUSPECT    = 4'b0010,
    MON_QUARANTINE = 4'b0100,
    MON_RECOVERY   = 4'b1000
  } mon_state_t;

  typedef struct packed {
    logic [39:0] max_primary_trace;
    logic [39:0] max_independent_trace;
    logic [19:0] max_independent_age;
    logic [15:0] aperture_multiplier;
    logic [23:0] aperture_min;
    logic [23:0] aperture_max;
    logic [1:0]  mode_bits;
    logic [23:0] streak_lengths;
  } cfg_t;

  typedef struct packed {
    logic [5:0]        flags;
    logic              p_healthy;
    logic              i_avail;
    logic              i_healthy;
    logic [2:0][34:0]  mag;
    logic [40:0]       trace_sum;
    logic [31:0]       generation;
  } item_t;

  typedef struct packed {
    logic [1:0]  monitor_state;
    logic [7:0]  recovery_run;
    logic        fix_permit;
    logic        request_reset;
    logic        promote_anchor;
    logic        agree;
    logic [4:0]  reason_bits;
    logic [63:0] distance_sq;
    logic [47:0] aperture_sq;
  } result_t;

  function automatic logic [CMP_W-1:0] streak_len(input logic [7:0] v);
    logic [CMP_W-1:0] r;
    r = CMP_W'(v);
    if (v == 8'd0) r = CMP_W'(1);
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] inc_sat(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] r;
    r = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
    return r;
  endfunction

  function automatic logic [CMP_W-1:0] cnt_ext(input logic [COUNT_BITS-1:0] c);
    return CMP_W'(c);
  endfunction

  function automatic logic [1:0] state_code(input mon_state_t s);
    logic [1:0] r;
    unique case (s)
      MON_NORMAL:     r = MS_NORMAL;
      MON_SUSPECT:    r = MS_SUSPECT;
      MON_QUARANTINE: r = MS_QUARANTINE;
      MON_RECOVERY:   r = MS_RECOVERY;
      default:        r = MS_NORMAL;
    endcase
    return r;
  endfunction
endpackage

@@ rtl/fic_front.sv @@
// Front end: accepts input beats, grades both fixes and forms axis distances.
// Depends on fic_pkg.
`timescale 1ns / 1ps
module fic_front (
  input  fic_pkg::cfg_t   cfg,
  input  logic [5:0]      flags,
  input  logic [33:0]     primary_x,
  input  logic [33:0]     primary_y,
  input  logic [33:0]     primary_z,
  input  logic [39:0]     primary_trace,
  input  logic [33:0]     indep_x,
  input  logic [33:0]     indep_y,
  input  logic [33:0]     indep_z,
  input  logic [39:0]     indep_trace,
  input  logic [19:0]     indep_age,
  input  logic [31:0]     indep_generation,
  output fic_pkg::item_t  item
);
  logic [2:0][33:0] pa;
  logic [2:0][33:0] ia;
  logic [2:0][34:0] diff;

  assign pa = {primary_z, primary_y, primary_x};
  assign ia = {indep_z, indep_y, indep_x};

  always_comb begin
    item = '0;
    item.flags = flags;
    item.p_healthy = flags[0] && (primary_trace <= cfg.max_primary_trace);
    item.i_avail = flags[1] && (indep_age <= cfg.max_independent_age);
    item.i_healthy = item.i_avail && (indep_trace <= cfg.max_independent_trace);
    for (int k = 0; k < 3; k++) begin
      diff[k] = {pa[k][33], pa[k]} - {ia[k][33], ia[k]};
      item.mag[k] = diff[k][34] ? (35'd0 - diff[k]) : diff[k];
    end
    item.trace_sum = {1'b0, primary_trace} + {1'b0, indep_trace};
    item.generation = indep_generation;
  end
endmodule

@@ rtl/fic_queue.sv @@
// Two-entry queue of graded items between the front and back ends.
// Depends on fic_pkg.
`timescale 1ns / 1ps
module fic_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fic_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output fic_pkg::item_t  head
);
  fic_pkg::item_t mem [2];
  logic rd_ptr, wr_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end
endmodule

@@ rtl/fic_back.sv @@
// Back end: shared multiplier sequence for distance and aperture, then the
// four-state monitor update and the output register. Depends on fic_pkg.
`timescale 1ns / 1ps
module fic_back (
  input  logic              clk,
  input  logic              rst,
  input  fic_pkg::cfg_t     cfg,
  input  logic              q_empty,
  input  fic_pkg::item_t    q_head,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output fic_pkg::result_t  res
);
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_MUL  = 3'b010,
    SEQ_FIN  = 3'b100
  } seq_t;

  seq_t seq;
  logic [2:0] step;
  fic_pkg::item_t it;
  logic [63:0] dsq;
  logic [63:0] ap;
  logic [31:0] m2;
  logic [47:0] lo_sq;
  logic [31:0] op_a, op_b;
  logic [63:0] prod;
  logic axis_big;
  logic [64:0] dist_sum;
  logic [63:0] ap_raised;

  fic_pkg::mon_state_t st, st_next;
  logic [fic_pkg::COUNT_BITS-1:0] sr, dr, rr, sr_next, dr_next, rr_next, rinc;
  logic [31:0] last_gen;
  logic gen_seen;
  fic_pkg::result_t res_next;
  logic fin_fire;

  logic fixed, sus, hard, rec_h, both, agr, eff, gen_changed, disagreement;
  logic [fic_pkg::CMP_W-1:0] len_s, len_q, len_r, rr_ext;

  assign q_pop = (seq == SEQ_IDLE) && !q_empty;
  assign fin_fire = (seq == SEQ_FIN) && (!res_valid || res_ready);

  always_comb begin
    op_a = '0;
    op_b = '0;
    axis_big = 1'b0;
    case (step)
      3'd0, 3'd1, 3'd2: begin
        op_a = it.mag[step[1:0]][31:0];
        op_b = it.mag[step[1:0]][31:0];
        axis_big = |it.mag[step[1:0]][34:32];
      end
      3'd3: begin
        op_a = {16'd0, cfg.aperture_multiplier};
        op_b = {16'd0, cfg.aperture_multiplier};
      end
      3'd4: begin
        op_a = m2;
        op_b = {7'd0, it.trace_sum[40:16]};
      end
      3'd5: begin
        op_a = m2;
        op_b = {16'd0, it.trace_sum[15:0]};
      end
      3'd6: begin
        op_a = {8'd0, cfg.aperture_min};
        op_b = {8'd0, cfg.aperture_min};
      end
      default: begin
        op_a = {8'd0, cfg.aperture_max};
        op_b = {8'd0, cfg.aperture_max};
      end
    endcase
    prod = op_a * op_b;
    dist_sum = {1'b0, dsq} + {1'b0, prod};
    ap_raised = (ap < {16'd0, lo_sq}) ? {16'd0, lo_sq} : ap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_IDLE;
      step <= 3'd0;
    end else begin
      unique case (seq)
        SEQ_IDLE: begin
          if (!q_empty) begin
            seq <= SEQ_MUL;
            step <= 3'd0;
          end
        end
        SEQ_MUL: begin
          step <= step + 3'd1;
          if (step == fic_pkg::SEQ_LAST_STEP) seq <= SEQ_FIN;
        end
        SEQ_FIN: begin
          if (fin_fire) seq <= SEQ_IDLE;
        end
        default: seq <= SEQ_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      it <= q_head;
      dsq <= '0;
    end
    if (seq == SEQ_MUL) begin
      case (step)
        3'd0, 3'd1, 3'd2: begin
          if (axis_big || dist_sum[64]) dsq <= '1;
          else dsq <= dist_sum[63:0];
        end
        3'd3: m2 <= prod[31:0];
        3'd4: ap <= prod;
        3'd5: ap <= ap + {16'd0, prod[63:16]};
        3'd6: lo_sq <= prod[47:0];
        default: ap <= (ap_raised > prod) ? prod : ap_raised;
      endcase
    end
  end

  always_comb begin
    fixed = it.flags[2];
    sus = it.flags[3];
    hard = it.flags[4];
    rec_h = it.flags[5];
    both = it.p_healthy && it.i_healthy;
    agr = both && (dsq <= ap);
    eff = sus && (it.i_healthy || !cfg.mode_bits[0]) && (!it.i_healthy || !agr);
    gen_changed = gen_seen && (it.generation != last_gen);
    disagreement = fixed && both && !agr && (!cfg.mode_bits[1] || sus);
    len_s = fic_pkg::streak_len(cfg.streak_lengths[7:0]);
    len_q = fic_pkg::streak_len(cfg.streak_lengths[15:8]);
    len_r = fic_pkg::streak_len(cfg.streak_lengths[23:16]);
    sr_next = eff ? fic_pkg::inc_sat(sr) : '0;
    dr_next = disagreement ? fic_pkg::inc_sat(dr) : '0;
    rr_next = rr;
    rinc = fic_pkg::inc_sat(rr);
    st_next = st;
    res_next = '0;
    unique case (st)
      fic_pkg::MON_NORMAL: begin
        if (hard) begin
          st_next = fic_pkg::MON_QUARANTINE;
          rr_next = '0;
          res_next.request_reset = 1'b1;
        end else if (fic_pkg::cnt_ext(sr_next) >= len_s ||
                     fic_pkg::cnt_ext(dr_next) >= len_s) begin
          st_next = fic_pkg::MON_SUSPECT;
        end
      end
      fic_pkg::MON_SUSPECT: begin
        if (hard || fic_pkg::cnt_ext(sr_next) >= len_q ||
            fic_pkg::cnt_ext(dr_next) >= len_q) begin
          st_next = fic_pkg::MON_QUARANTINE;
          rr_next = '0;
          res_next.request_reset = 1'b1;
        end else if (!eff && !disagreement) begin
          st_next = fic_pkg::MON_NORMAL;
        end
      end
      fic_pkg::MON_QUARANTINE: begin
        if (fixed && agr && !eff && !gen_changed) begin
          st_next = fic_pkg::MON_RECOVERY;
          rr_next = fic_pkg::COUNT_BITS'(1);
        end
      end
      fic_pkg::MON_RECOVERY: begin
        if (gen_changed || eff || (fixed && !agr)) begin
          st_next = fic_pkg::MON_QUARANTINE;
          rr_next = '0;
        end else if (fixed && agr) begin
          if (fic_pkg::cnt_ext(rinc) >= len_r) begin
            st_next = fic_pkg::MON_NORMAL;
            rr_next = '0;
            sr_next = '0;
            dr_next = '0;
            res_next.promote_anchor = 1'b1;
          end else begin
            rr_next = rinc;
          end
        end
      end
      default: st_next = fic_pkg::MON_NORMAL;
    endcase
    rr_ext = fic_pkg::cnt_ext(rr_next);
    res_next.monitor_state = fic_pkg::state_code(st_next);
    res_next.recovery_run = rr_ext[7:0];
    res_next.fix_permit = !fixed || (st_next == fic_pkg::MON_NORMAL) ||
                          ((st_next == fic_pkg::MON_RECOVERY) && agr && rec_h);
    res_next.agree = agr;
    res_next.reason_bits[fic_pkg::R_UNAVAIL] = !it.i_avail;
    res_next.reason_bits[fic_pkg::R_UNCERTAIN] = it.i_avail && !it.i_healthy;
    res_next.reason_bits[fic_pkg::R_DISAGREE] = both && !agr;
    res_next.reason_bits[fic_pkg::R_SUSPECT] = sus || hard;
    res_next.reason_bits[fic_pkg::R_GEN] = gen_changed;
    res_next.distance_sq = both ? dsq : '0;
    res_next.aperture_sq = both ? ap[47:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fic_pkg::MON_NORMAL;
      sr <= '0;
      dr <= '0;
      rr <= '0;
      last_gen <= '0;
      gen_seen <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= fin_fire || (res_valid && !res_ready);
      if (fin_fire) begin
        st <= st_next;
        sr <= sr_next;
        dr <= dr_next;
        rr <= rr_next;
        if (it.i_avail) begin
          last_gen <= it.generation;
          gen_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) res <= res_next;
  end
endmodule

@@ rtl/fix_integrity_consensus_fsm.sv @@
// Top level of the fix integrity consensus monitor: configuration registers,
// front end, item queue and back end. Depends on fic_pkg and the defines header.
//
// Usage: one input beat per epoch on the s_ channel (positions, traces, age,
// generation in tdata; flags in tuser). One result beat per input beat on the
// m_ channel, in order. Registers are read back over the APB-style port at
// any time. The user must write them over that port only while the block is
// idle; the block itself does not enforce this.
// The back end takes one item at a time from the queue: a load state, eight
// steps through one 32x32 multiplier (three axis squares, the multiplier
// square, two aperture partial products, two clamp squares) and a monitor
// update state.
// The front end grades items on entry and a two-entry queue holds them, so
// s_tready stays high until the queue is full.
// Reset clears the monitor state, streak counters, generation tracking, the
// queue and the output beat, and loads the register defaults.
// When the receiver stalls, the result beat holds on m_tdata, the back end
// finishes the next item and waits, and input beats back up into the queue.
`timescale 1ns / 1ps
`include "fix_integrity_consensus_fsm_defines.svh"
module fix_integrity_consensus_fsm (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // primary_x, primary_y, primary_z, primary_trace, indep_x, indep_y, indep_z,
  // indep_trace, indep_age, indep_generation
  input  logic [335:0] s_tdata,
  // flags
  input  logic [5:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // monitor_state, recovery_run, fix_permit, request_reset, promote_anchor,
  // agree, reason_bits, distance_sq, aperture_sq, zero fill
  output logic [135:0] m_tdata
);
  fic_pkg::cfg_t cfg;
  fic_pkg::item_t f_item, q_head;
  fic_pkg::result_t res;
  logic q_full, q_empty, q_pop, wr_en, in_fire;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign s_tready = !q_full;
  assign in_fire = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_primary_trace <= 40'hFF_FFFF_FFFF;
      cfg.max_independent_trace <= 40'hFF_FFFF_FFFF;
      cfg.max_independent_age <= 20'd1000;
      cfg.aperture_multiplier <= 16'd768;
      cfg.aperture_min <= 24'd0;
      cfg.aperture_max <= 24'hFF_FFFF;
      cfg.mode_bits <= 2'd0;
      cfg.streak_lengths <= 24'd197379;
    end else if (wr_en) begin
      unique case (paddr[5:3])
        fic_pkg::REG_MAX_PTRACE: cfg.max_primary_trace <= pwdata[39:0];
        fic_pkg::REG_MAX_ITRACE: cfg.max_independent_trace <= pwdata[39:0];
        fic_pkg::REG_MAX_AGE:    cfg.max_independent_age <= pwdata[19:0];
        fic_pkg::REG_AP_MULT:    cfg.aperture_multiplier <= pwdata[15:0];
        fic_pkg::REG_AP_MIN:     cfg.aperture_min <= pwdata[23:0];
        fic_pkg::REG_AP_MAX:     cfg.aperture_max <= pwdata[23:0];
        fic_pkg::REG_MODE:       cfg.mode_bits <= pwdata[1:0];
        fic_pkg::REG_STREAKS:    cfg.streak_lengths <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      fic_pkg::REG_MAX_PTRACE: prdata = {24'd0, cfg.max_primary_trace};
      fic_pkg::REG_MAX_ITRACE: prdata = {24'd0, cfg.max_independent_trace};
      fic_pkg::REG_MAX_AGE:    prdata = {44'd0, cfg.max_independent_age};
      fic_pkg::REG_AP_MULT:    prdata = {48'd0, cfg.aperture_multiplier};
      fic_pkg::REG_AP_MIN:     prdata = {40'd0, cfg.aperture_min};
      fic_pkg::REG_AP_MAX:     prdata = {40'd0, cfg.aperture_max};
      fic_pkg::REG_MODE:       prdata = {62'd0, cfg.mode_bits};
      fic_pkg::REG_STREAKS:    prdata = {40'd0, cfg.streak_lengths};
      default:                 prdata = '0;
    endcase
  end

  fic_front u_front (
    .cfg              (cfg),
    .flags            (s_tuser),
    .primary_x        (s_tdata[33:0]),
    .primary_y        (s_tdata[67:34]),
    .primary_z        (s_tdata[101:68]),
    .primary_trace    (s_tdata[141:102]),
    .indep_x          (s_tdata[175:142]),
    .indep_y          (s_tdata[209:176]),
    .indep_z          (s_tdata[243:210]),
    .indep_trace      (s_tdata[283:244]),
    .indep_age        (s_tdata[303:284]),
    .indep_generation (s_tdata[335:304]),
    .item             (f_item)
  );

  fic_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  fic_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {5'd0, res.aperture_sq, res.distance_sq, res.reason_bits, res.agree,
                    res.promote_anchor, res.request_reset, res.fix_permit,
                    res.recovery_run, res.monitor_state};

  `FIC_ASSERT_CLK(a_promote_normal, m_tvalid && res.promote_anchor |-> res.monitor_state == fic_pkg::MS_NORMAL)
  `FIC_ASSERT_CLK(a_reset_quar, m_tvalid && res.request_reset |-> res.monitor_state == fic_pkg::MS_QUARANTINE)
  `FIC_ASSERT_CLK(a_agree_dist, m_tvalid && res.agree |-> res.distance_sq <= {16'd0, res.aperture_sq})
  `FIC_ASSERT_RST(a_rst_idle, rst |=> !m_tvalid && s_tready)
endmodule
